// ===== hw/rtl/png_unf_pkg.sv =====
// Shared types, codes and defaults of the PNG scanline unfilter.
`timescale 1ns / 1ps
`default_nettype none

package png_unf_pkg;

	localparam int DATA_W      = 8;
	localparam int WIDTH_REG_W = 11;
	localparam int HEIGHT_W    = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int FILTER_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [FILTER_W-1:0] FLT_NONE  = 3'd0;
	localparam logic [FILTER_W-1:0] FLT_SUB   = 3'd1;
	localparam logic [FILTER_W-1:0] FLT_UP    = 3'd2;
	localparam logic [FILTER_W-1:0] FLT_AVG   = 3'd3;
	localparam logic [FILTER_W-1:0] FLT_PAETH = 3'd4;

	// Largest legal filter type byte.
	localparam logic [DATA_W-1:0] FILTER_MAX = 8'd4;

	localparam int DEF_MAX_WIDTH       = 1024;
	localparam int DEF_BYTES_PER_PIXEL = 4;

	// Depths of the queue between the halves and of the result queue.
	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	// One classified byte handed from the front to the back.
	typedef struct packed {
		logic [DATA_W-1:0]   data;
		logic [FILTER_W-1:0] filter;
		logic                a_ok;     // a left neighbor exists in this row
		logic                b_ok;     // an upper row exists
		logic                end_row;
		logic                end_img;
		logic                bad;      // error beat for an unknown filter type
	} op_t;

	// One result beat.
	typedef struct packed {
		logic [DATA_W-1:0] pixel_byte;
		logic              last_in_row;
		logic              last_in_image;
		logic              bad_filter;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/png_unf_fifo.sv =====
// Small first-in first-out queue used between and behind the two halves.
`timescale 1ns / 1ps
`default_nettype none

module png_unf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wr_data,
	output logic                         full,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rd_data,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   level
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (level_q == LVL_W'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rd_data = store_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (do_pop && !do_push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/png_unf_front.sv =====
// Front half: configuration registers, row and column tracking, byte classification.
`timescale 1ns / 1ps
`default_nettype none

module png_unf_front #(
	parameter int MAX_WIDTH       = png_unf_pkg::DEF_MAX_WIDTH,
	parameter int BYTES_PER_PIXEL = png_unf_pkg::DEF_BYTES_PER_PIXEL,
	parameter int COL_W           = 12,
	parameter int LANE_W          = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [png_unf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [png_unf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                                in_valid,
	input  logic [png_unf_pkg::DATA_W-1:0]      data_byte,
	input  logic                                start_of_image,
	output logic                                op_push,
	output logic [LANE_W-1:0]                   op_lane,
	output logic [COL_W-1:0]                    op_col,
	output png_unf_pkg::op_t                    op
);

	import png_unf_pkg::*;

	localparam int ROW_MAX = MAX_WIDTH * BYTES_PER_PIXEL;
	localparam int RB_W    = $clog2(ROW_MAX + 1);

	logic [WIDTH_REG_W-1:0] width_q;
	logic [HEIGHT_W-1:0]    height_q;
	logic [COL_W-1:0]       col_q;
	logic [LANE_W-1:0]      lane_q;
	logic [HEIGHT_W-1:0]    row_q;
	logic [FILTER_W-1:0]    filter_q;
	logic                   await_q;
	logic                   halted_q;

	logic [RB_W-1:0]     w_eff;
	logic [RB_W-1:0]     row_bytes;
	logic [HEIGHT_W-1:0] h_eff;
	logic                e_halt;
	logic                e_await;
	logic [HEIGHT_W-1:0] e_row;
	logic [COL_W-1:0]    e_col;
	logic [LANE_W-1:0]   e_lane;
	logic [COL_W-1:0]    col_c;
	logic [LANE_W-1:0]   lane_c;
	logic                end_row;
	logic                end_img;
	logic                emit;

	logic                nxt_halt;
	logic                nxt_await;
	logic [HEIGHT_W-1:0] nxt_row;
	logic [COL_W-1:0]    nxt_col;
	logic [LANE_W-1:0]   nxt_lane;
	logic [FILTER_W-1:0] nxt_filter;

	// Effective geometry: a width of zero counts as one, a width past the line buffer is cut.
	always_comb begin
		if (width_q == '0) begin
			w_eff = RB_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = RB_W'(MAX_WIDTH);
		end else begin
			w_eff = RB_W'(width_q);
		end
		row_bytes = w_eff * RB_W'(BYTES_PER_PIXEL);
		h_eff     = (height_q == '0) ? HEIGHT_W'(1) : height_q;
	end

	// Start of image overrides the position state for this byte.
	always_comb begin
		e_halt  = start_of_image ? 1'b0 : halted_q;
		e_await = start_of_image ? 1'b1 : await_q;
		e_row   = start_of_image ? '0 : row_q;
		e_col   = start_of_image ? '0 : col_q;
		e_lane  = start_of_image ? '0 : lane_q;

		// A column at or past a shrunken row end is pinned to the last byte of the row.
		if (RB_W'(e_col) >= row_bytes) begin
			col_c  = COL_W'(row_bytes - RB_W'(1));
			lane_c = LANE_W'(BYTES_PER_PIXEL - 1);
		end else begin
			col_c  = e_col;
			lane_c = e_lane;
		end
		end_row = (RB_W'(col_c) + RB_W'(1)) >= row_bytes;
		end_img = end_row && (({1'b0, e_row} + 17'd1) >= {1'b0, h_eff});
	end

	always_comb begin
		emit       = 1'b0;
		op         = '0;
		nxt_halt   = e_halt;
		nxt_await  = e_await;
		nxt_row    = e_row;
		nxt_col    = e_col;
		nxt_lane   = e_lane;
		nxt_filter = filter_q;
		if (!e_halt) begin
			if (e_await) begin
				if (data_byte > FILTER_MAX) begin
					emit     = 1'b1;
					op.bad   = 1'b1;
					nxt_halt = 1'b1;
				end else begin
					nxt_filter = data_byte[FILTER_W-1:0];
					nxt_await  = 1'b0;
					nxt_col    = '0;
					nxt_lane   = '0;
				end
			end else begin
				emit       = 1'b1;
				op.data    = data_byte;
				op.filter  = filter_q;
				op.a_ok    = RB_W'(col_c) >= RB_W'(BYTES_PER_PIXEL);
				op.b_ok    = (e_row != '0);
				op.end_row = end_row;
				op.end_img = end_img;
				if (end_row) begin
					nxt_col   = '0;
					nxt_lane  = '0;
					nxt_await = 1'b1;
					nxt_row   = end_img ? '0 : e_row + HEIGHT_W'(1);
					nxt_halt  = end_img;
				end else begin
					nxt_col  = col_c + COL_W'(1);
					nxt_lane = (lane_c == LANE_W'(BYTES_PER_PIXEL - 1)) ?
						'0 : lane_c + LANE_W'(1);
				end
			end
		end
	end

	assign op_push = in_valid && emit;
	assign op_lane = lane_c;
	assign op_col  = col_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_REG_W'(1);
			height_q <= HEIGHT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[WIDTH_REG_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[HEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			lane_q   <= '0;
			row_q    <= '0;
			filter_q <= FLT_NONE;
			await_q  <= 1'b1;
			halted_q <= 1'b0;
		end else if (in_valid) begin
			col_q    <= nxt_col;
			lane_q   <= nxt_lane;
			row_q    <= nxt_row;
			filter_q <= nxt_filter;
			await_q  <= nxt_await;
			halted_q <= nxt_halt;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/png_unf_back.sv =====
// Back half: line buffer, neighbor registers and the reconstruction arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module png_unf_back #(
	parameter int MAX_WIDTH       = png_unf_pkg::DEF_MAX_WIDTH,
	parameter int BYTES_PER_PIXEL = png_unf_pkg::DEF_BYTES_PER_PIXEL,
	parameter int COL_W           = 12,
	parameter int LANE_W          = 2,
	parameter int OUT_DEPTH       = png_unf_pkg::OUT_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               op_avail,
	input  logic [LANE_W-1:0]                  op_lane,
	input  logic [COL_W-1:0]                   op_col,
	input  png_unf_pkg::op_t                   op,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_level,
	output logic                               op_take,
	output logic                               res_push,
	output png_unf_pkg::res_t                  res
);

	import png_unf_pkg::*;

	localparam int ROW_MAX = MAX_WIDTH * BYTES_PER_PIXEL;

	function automatic logic [8:0] abs_diff9(input logic [8:0] x, input logic [8:0] y);
		return (x > y) ? (x - y) : (y - x);
	endfunction

	logic [DATA_W-1:0] prior_row_mem [ROW_MAX];
	logic [DATA_W-1:0] left_q        [BYTES_PER_PIXEL];
	logic [DATA_W-1:0] upper_left_q  [BYTES_PER_PIXEL];

	logic              valid_s1;
	op_t               op_s1;
	logic [LANE_W-1:0] lane_s1;
	logic [COL_W-1:0]  col_s1;
	logic [DATA_W-1:0] upper_s1;

	logic [DATA_W-1:0] a;
	logic [DATA_W-1:0] b;
	logic [DATA_W-1:0] c;
	logic [8:0]        pa;
	logic [8:0]        pb;
	logic [8:0]        pc;
	logic [8:0]        sum_ab;
	logic [DATA_W-1:0] paeth;
	logic [DATA_W-1:0] pred;
	logic [DATA_W-1:0] recon;
	logic              commit;

	// A byte is taken only when the result queue has room for it and the one in flight.
	assign op_take = op_avail &&
		((32'(out_level) + 32'(valid_s1)) < 32'(OUT_DEPTH));

	always_ff @(posedge clk) begin
		if (op_take) begin
			upper_s1 <= prior_row_mem[op_col];
			op_s1    <= op;
			lane_s1  <= op_lane;
			col_s1   <= op_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= op_take;
		end
	end

	always_comb begin
		a      = op_s1.a_ok ? left_q[lane_s1] : '0;
		b      = op_s1.b_ok ? upper_s1 : '0;
		c      = (op_s1.a_ok && op_s1.b_ok) ? upper_left_q[lane_s1] : '0;
		sum_ab = {1'b0, a} + {1'b0, b};
		pa     = abs_diff9({1'b0, b}, {1'b0, c});
		pb     = abs_diff9({1'b0, a}, {1'b0, c});
		pc     = abs_diff9(sum_ab, {c, 1'b0});
		if (pa <= pb && pa <= pc) begin
			paeth = a;
		end else if (pb <= pc) begin
			paeth = b;
		end else begin
			paeth = c;
		end
		case (op_s1.filter)
			FLT_SUB:   pred = a;
			FLT_UP:    pred = b;
			FLT_AVG:   pred = sum_ab[8:1];
			FLT_PAETH: pred = paeth;
			default:   pred = '0;
		endcase
		recon  = op_s1.data + pred;
		commit = valid_s1 && !op_s1.bad;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			prior_row_mem[col_s1] <= recon;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			left_q[lane_s1]       <= recon;
			upper_left_q[lane_s1] <= b;
		end
	end

	always_comb begin
		res_push          = valid_s1;
		res.pixel_byte    = op_s1.bad ? '0 : recon;
		res.last_in_row   = op_s1.end_row;
		res.last_in_image = op_s1.end_img;
		res.bad_filter    = op_s1.bad;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/png_scanline_unfilter_rgba8.sv =====
// Top level of the PNG scanline unfilter for 8-bit RGBA images.
//
// Usage: the inflated, filtered stream enters one byte per beat on the input
// queue (push, full). The first byte of each row is its filter type, and
// start_of_image marks the first byte of a new image. Rebuilt bytes leave on
// the result queue (empty, pop) with flags for the last byte of a row and of
// the image. A filter type above four yields a single error beat, after which
// bytes are dropped until the next start of image; the same holds after the
// last byte of an image. Filter bytes yield no result beat.
// Configuration: image_width (index 0) and image_height (index 1) are written
// through cfg_we, cfg_index and cfg_data; the user must write them only while
// the block is idle; the block leaves this unchecked. Throughput: one byte
// per cycle, sustained while the receiver pops. The classifier feeds a
// two-entry queue; the reconstruction stage registers its line buffer read
// ahead of its arithmetic, and a four-entry result queue absorbs a stalled
// receiver. When pop stays low the result queue fills, the middle queue
// backs up, and full rises; nothing is lost.
// Reset: position and configuration return to their defaults at once. The
// line buffer is not cleared; the first row ignores what it reads there.
`timescale 1ns / 1ps
`default_nettype none

module png_scanline_unfilter_rgba8 #(
	parameter int MAX_WIDTH       = png_unf_pkg::DEF_MAX_WIDTH,
	parameter int BYTES_PER_PIXEL = png_unf_pkg::DEF_BYTES_PER_PIXEL
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [png_unf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [png_unf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                               push,
	output logic                               full,
	input  logic [png_unf_pkg::DATA_W-1:0]     data_byte,
	input  logic                               start_of_image,
	output logic                               empty,
	input  logic                               pop,
	output logic [png_unf_pkg::DATA_W-1:0]     pixel_byte,
	output logic                               last_in_row,
	output logic                               last_in_image,
	output logic                               bad_filter
);

	import png_unf_pkg::*;

	localparam int ROW_MAX = MAX_WIDTH * BYTES_PER_PIXEL;
	localparam int COL_W   = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
	localparam int LANE_W  = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1;
	localparam int MID_W   = LANE_W + COL_W + $bits(op_t);
	localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

	logic              in_valid;
	logic              op_push;
	logic [LANE_W-1:0] op_lane;
	logic [COL_W-1:0]  op_col;
	op_t               op;

	logic [MID_W-1:0]  mid_rd;
	logic              mid_empty;
	logic              op_take;
	logic [LANE_W-1:0] back_lane;
	logic [COL_W-1:0]  back_col;
	op_t               back_op;

	logic              res_push;
	res_t              res;
	res_t              res_head;
	logic [OUT_LVL_W-1:0] out_level;

	assign in_valid = push && !full;

	png_unf_front #(
		.MAX_WIDTH       (MAX_WIDTH),
		.BYTES_PER_PIXEL (BYTES_PER_PIXEL),
		.COL_W           (COL_W),
		.LANE_W          (LANE_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.data_byte      (data_byte),
		.start_of_image (start_of_image),
		.op_push        (op_push),
		.op_lane        (op_lane),
		.op_col         (op_col),
		.op             (op)
	);

	// The input side stalls only on the middle queue, so bytes that give no
	// result wait for room as well; this keeps the classifier a single stage.
	png_unf_fifo #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (op_push),
		.wr_data ({op_lane, op_col, op}),
		.full    (full),
		.pop     (op_take),
		.rd_data (mid_rd),
		.empty   (mid_empty),
		.level   ()
	);

	assign {back_lane, back_col, back_op} = mid_rd;

	png_unf_back #(
		.MAX_WIDTH       (MAX_WIDTH),
		.BYTES_PER_PIXEL (BYTES_PER_PIXEL),
		.COL_W           (COL_W),
		.LANE_W          (LANE_W),
		.OUT_DEPTH       (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_avail  (!mid_empty),
		.op_lane   (back_lane),
		.op_col    (back_col),
		.op        (back_op),
		.out_level (out_level),
		.op_take   (op_take),
		.res_push  (res_push),
		.res       (res)
	);

	png_unf_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res),
		.full    (),
		.pop     (pop),
		.rd_data (res_head),
		.empty   (empty),
		.level   (out_level)
	);

	assign pixel_byte    = res_head.pixel_byte;
	assign last_in_row   = res_head.last_in_row;
	assign last_in_image = res_head.last_in_image;
	assign bad_filter    = res_head.bad_filter;

endmodule

`default_nettype wire
